@@ src/rqy_pkg.sv @@
// types and fixed-point weights for the 2x2 rgb to yuv block converter
package rqy_pkg;

    // luma weights, Q20
    localparam logic [19:0] WY_R = 20'd299578;
    localparam logic [19:0] WY_G = 20'd599156;
    localparam logic [19:0] WY_B = 20'd149841;

    // chroma weights, Q20, signed
    localparam logic signed [31:0] WU_R = -32'sd149841;
    localparam logic signed [31:0] WU_G = -32'sd299578;
    localparam logic signed [31:0] WU_B = 32'sd449419;
    localparam logic signed [31:0] WV_R = 32'sd374446;
    localparam logic signed [31:0] WV_G = -32'sd299578;
    localparam logic signed [31:0] WV_B = -32'sd74868;

    localparam int Q_SHIFT = 20;
    localparam int CHROMA_OFFSET = 128;

    localparam int PROD_W = 28;     // 8 bit channel times 20 bit weight
    localparam int SUM_W = 10;      // channel sum over four pixels

    typedef struct packed {
        logic [7:0] red_tl;
        logic [7:0] green_tl;
        logic [7:0] blue_tl;
        logic [7:0] red_tr;
        logic [7:0] green_tr;
        logic [7:0] blue_tr;
        logic [7:0] red_bl;
        logic [7:0] green_bl;
        logic [7:0] blue_bl;
        logic [7:0] red_br;
        logic [7:0] green_br;
        logic [7:0] blue_br;
    } rqy_pixel_t;

    typedef struct packed {
        logic [7:0] luma_tl;
        logic [7:0] luma_tr;
        logic [7:0] luma_bl;
        logic [7:0] luma_br;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } rqy_yuv_t;

    // load enables of the two middle pipeline stages
    typedef struct packed {
        logic prod;
        logic luma;
    } rqy_stage_en_t;

endpackage

@@ src/rqy_luma.sv @@
// per-pixel luma: registered weighted products, then registered rounded sum
module rqy_luma
    import rqy_pkg::*;
(
    input  logic          clk,
    input  rqy_stage_en_t en,
    input  logic [7:0]    red,
    input  logic [7:0]    green,
    input  logic [7:0]    blue,
    output logic [7:0]    luma
);

    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PROD_W-1:0] prod_r_next, prod_g_next, prod_b_next;
    logic [PROD_W-1:0] acc;
    logic [7:0]        luma_reg, luma_next;

    always_comb
    begin
        prod_r_next = PROD_W'(red) * PROD_W'(WY_R);
        prod_g_next = PROD_W'(green) * PROD_W'(WY_G);
        prod_b_next = PROD_W'(blue) * PROD_W'(WY_B);
        // weights sum to just under one, so the rounded sum fits 28 bits
        acc = prod_r_reg + prod_g_reg + prod_b_reg + PROD_W'(1 << (Q_SHIFT - 1));
        luma_next = acc[PROD_W-1:Q_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_r_reg <= prod_r_next;
            prod_g_reg <= prod_g_next;
            prod_b_reg <= prod_b_next;
        end
        if (en.luma)
        begin
            luma_reg <= luma_next;
        end
    end

    assign luma = luma_reg;

endmodule

@@ src/rgb_quad_to_yuv_block_top.sv @@
// top level: 2x2 rgb block to four luma values and one shared chroma pair
//
// Takes one 2x2 block of 8-bit RGB pixels per word and returns four lumas and
// one chroma pair (U, V offset by 128 and saturated to 0..255). A new word is
// accepted every cycle while the output side keeps up; a result is offered once its
// word has passed the four register stages: input register, weighted products and
// channel sums, luma sums and chroma products, and the result register. Each full
// stage holds while the stage after it is full and stalled, so back pressure reaches
// pixel_ready in the same cycle.
module rgb_quad_to_yuv_block_top
    import rqy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  rqy_pixel_t pixel_block,
    output logic       yuv_valid,
    input  logic       yuv_ready,
    output rqy_yuv_t   yuv_block
);

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic load0, load1, load2, load3;
    rqy_stage_en_t luma_en;

    rqy_pixel_t pix_reg;

    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0] sum_r_next, sum_g_next, sum_b_next;

    logic signed [31:0] pu_r_reg, pu_g_reg, pu_b_reg;
    logic signed [31:0] pv_r_reg, pv_g_reg, pv_b_reg;
    logic signed [31:0] pu_r_next, pu_g_next, pu_b_next;
    logic signed [31:0] pv_r_next, pv_g_next, pv_b_next;

    logic [7:0] luma_tl, luma_tr, luma_bl, luma_br;
    rqy_yuv_t   out_reg, out_next;

    // rounded, floor-shifted by 22, offset and clamped to 0..255
    function automatic logic [7:0] chroma_sat(input logic signed [31:0] acc);
        logic signed [31:0] rnd;
        logic signed [10:0] val;
        rnd = acc + 32'sd2097152;
        val = 11'(signed'(rnd[31:22])) + 11'sd128;
        if (val < 11'sd0)
            return 8'd0;
        else if (val > 11'sd255)
            return 8'd255;
        else
            return val[7:0];
    endfunction

    // a stage loads when empty or when its contents move on this cycle
    always_comb
    begin
        load3 = !v3_reg || yuv_ready;
        load2 = !v2_reg || load3;
        load1 = !v1_reg || load2;
        load0 = !v0_reg || load1;
        luma_en.prod = load1;
        luma_en.luma = load2;
    end

    assign pixel_ready = load0;

    always_comb
    begin
        sum_r_next = SUM_W'(pix_reg.red_tl) + SUM_W'(pix_reg.red_tr)
                   + SUM_W'(pix_reg.red_bl) + SUM_W'(pix_reg.red_br);
        sum_g_next = SUM_W'(pix_reg.green_tl) + SUM_W'(pix_reg.green_tr)
                   + SUM_W'(pix_reg.green_bl) + SUM_W'(pix_reg.green_br);
        sum_b_next = SUM_W'(pix_reg.blue_tl) + SUM_W'(pix_reg.blue_tr)
                   + SUM_W'(pix_reg.blue_bl) + SUM_W'(pix_reg.blue_br);

        pu_r_next = signed'({22'd0, sum_r_reg}) * WU_R;
        pu_g_next = signed'({22'd0, sum_g_reg}) * WU_G;
        pu_b_next = signed'({22'd0, sum_b_reg}) * WU_B;
        pv_r_next = signed'({22'd0, sum_r_reg}) * WV_R;
        pv_g_next = signed'({22'd0, sum_g_reg}) * WV_G;
        pv_b_next = signed'({22'd0, sum_b_reg}) * WV_B;

        out_next.luma_tl  = luma_tl;
        out_next.luma_tr  = luma_tr;
        out_next.luma_bl  = luma_bl;
        out_next.luma_br  = luma_br;
        out_next.chroma_u = chroma_sat(pu_r_reg + pu_g_reg + pu_b_reg);
        out_next.chroma_v = chroma_sat(pv_r_reg + pv_g_reg + pv_b_reg);
    end

    rqy_luma u_luma_tl (
        .clk   (clk),
        .en    (luma_en),
        .red   (pix_reg.red_tl),
        .green (pix_reg.green_tl),
        .blue  (pix_reg.blue_tl),
        .luma  (luma_tl)
    );

    rqy_luma u_luma_tr (
        .clk   (clk),
        .en    (luma_en),
        .red   (pix_reg.red_tr),
        .green (pix_reg.green_tr),
        .blue  (pix_reg.blue_tr),
        .luma  (luma_tr)
    );

    rqy_luma u_luma_bl (
        .clk   (clk),
        .en    (luma_en),
        .red   (pix_reg.red_bl),
        .green (pix_reg.green_bl),
        .blue  (pix_reg.blue_bl),
        .luma  (luma_bl)
    );

    rqy_luma u_luma_br (
        .clk   (clk),
        .en    (luma_en),
        .red   (pix_reg.red_br),
        .green (pix_reg.green_br),
        .blue  (pix_reg.blue_br),
        .luma  (luma_br)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load0) v0_reg <= pixel_valid;
            if (load1) v1_reg <= v0_reg;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            pix_reg <= pixel_block;
        end
        if (load1)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (load2)
        begin
            pu_r_reg <= pu_r_next;
            pu_g_reg <= pu_g_next;
            pu_b_reg <= pu_b_next;
            pv_r_reg <= pv_r_next;
            pv_g_reg <= pv_g_next;
            pv_b_reg <= pv_b_next;
        end
        if (load3)
        begin
            out_reg <= out_next;
        end
    end

    assign yuv_valid = v3_reg;
    assign yuv_block = out_reg;

endmodule
